[rtl/tpl_pkg.sv]
// Shared types, constants and helper function of the point list proximity block.
package tpl_pkg;

  localparam int DEPTH = 16;
  localparam int DIMS  = 4;
  localparam int CW    = 16;
  localparam int IDXW  = $clog2(DEPTH);
  localparam int CNTW  = $clog2(DEPTH + 1);
  localparam int RADW  = 36;
  localparam int CAPW  = 5;
  localparam int SQW   = 2 * CW;
  localparam int SUMW  = SQW + 2;
  localparam int CFGAW = 1;

  localparam logic [CFGAW-1:0] CFG_RADIUS   = 1'b0;
  localparam logic [CFGAW-1:0] CFG_CAPACITY = 1'b1;

  typedef enum logic [1:0] {
    ACT_INSERT = 2'd0,
    ACT_NEAR   = 2'd1,
    ACT_EXACT  = 2'd2,
    ACT_CLEAR  = 2'd3
  } tpl_act_t;

  typedef logic [DIMS-1:0][CW-1:0] point_t;

  // Query request walking down the cell row. The pending fields carry the
  // partial evaluation of the previous cell's entry.
  typedef struct packed {
    logic                      valid;
    logic                      near;
    point_t                    pt;
    logic                      pend_vld;
    logic [IDXW-1:0]           pend_idx;
    logic [DIMS-1:0][SQW-1:0]  pend_sq;
    logic                      pend_eq;
    logic                      found;
    logic [IDXW-1:0]           idx;
  } tpl_tok_t;

  function automatic logic tpl_match(input tpl_tok_t tok, input logic [RADW-1:0] radius);
    logic [SUMW-1:0] sum;
    sum = '0;
    for (int k = 0; k < DIMS; k++) begin
      sum = sum + SUMW'(tok.pend_sq[k]);
    end
    return tok.pend_vld && (tok.near ? (RADW'(sum) <= radius) : tok.pend_eq);
  endfunction

endpackage

[rtl/tpl_cell.sv]
// One list entry: stored point, shift on insert, per-entry stage of the query walk.
module tpl_cell (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic [tpl_pkg::IDXW-1:0] cell_idx,
  input  logic [tpl_pkg::CNTW-1:0] count,
  input  logic [tpl_pkg::RADW-1:0] radius,
  input  logic                     shift_en,
  input  tpl_pkg::point_t          point_in,
  output tpl_pkg::point_t          point_out,
  input  tpl_pkg::tpl_tok_t        tok_in,
  output tpl_pkg::tpl_tok_t        tok_out
);
  import tpl_pkg::*;

  point_t   point_r;
  tpl_tok_t tok_r;
  tpl_tok_t tok_nxt;

  always_comb begin
    logic signed [CW:0] diff;
    logic        [CW:0] mag;
    tok_nxt = tok_in;
    if (tpl_match(tok_in, radius) && !tok_in.found) begin
      tok_nxt.found = 1'b1;
      tok_nxt.idx   = tok_in.pend_idx;
    end
    tok_nxt.pend_vld = (CNTW'(cell_idx) < count);
    tok_nxt.pend_idx = cell_idx;
    tok_nxt.pend_eq  = 1'b1;
    for (int k = 0; k < DIMS; k++) begin
      diff = $signed({point_r[k][CW-1], point_r[k]}) - $signed({tok_in.pt[k][CW-1], tok_in.pt[k]});
      mag  = diff[CW] ? (CW+1)'(-diff) : diff;
      tok_nxt.pend_sq[k] = mag[CW-1:0] * mag[CW-1:0];
      if (point_r[k] != tok_in.pt[k]) begin
        tok_nxt.pend_eq = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (shift_en) begin
      point_r <= point_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r.valid <= 1'b0;
    end else begin
      tok_r <= tok_nxt;
    end
  end

  assign point_out = point_r;
  assign tok_out   = tok_r;

endmodule

[rtl/tabu_point_list_proximity.sv]
// Top level of the point list proximity block: control, config and the cell row.
//
//  channel | dir | handshake           | payload
//  in_     | in  | in_tvalid/in_tready | tuser action, tdata four Q8.8 coordinates
//  out_    | out | tvalid/tready       | tdata hit, match_index, entry_count
//  cfg_    | in  | cfg_wr_en           | cfg_addr, cfg_wr_data
//
//  Insert and clear: result is registered in the cycle after the request.
//  Near and exact queries: the request walks the 16 cells one per cycle and the
//  result is registered after the last cell; no new request is taken during the walk.
//  Sync active-low reset empties the list; stored points are not cleared.
//  A waiting result holds the input off unless it is taken in the same cycle.
module tabu_point_list_proximity (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_tvalid,
  output logic                      in_tready,
  input  logic [63:0]               in_tdata,   // coord_a, coord_b, coord_c, coord_d
  input  logic [1:0]                in_tuser,   // action
  output logic                      out_tvalid,
  input  logic                      out_tready,
  output logic [15:0]               out_tdata,  // hit, match_index, entry_count, zero pad
  input  logic                      cfg_wr_en,
  input  logic [tpl_pkg::CFGAW-1:0] cfg_addr,
  input  logic [tpl_pkg::RADW-1:0]  cfg_wr_data
);
  import tpl_pkg::*;

  typedef enum logic {S_IDLE, S_SCAN} state_t;

  localparam int OUTW = 1 + IDXW + CNTW;

  state_t            state_r, state_nxt;
  logic [CNTW-1:0]   count_r, count_nxt;
  logic [RADW-1:0]   radius_r;
  logic [CAPW-1:0]   capacity_r;
  logic              out_tvalid_r, out_tvalid_nxt;
  logic [OUTW-1:0]   out_data_r, out_data_nxt;
  logic              out_load;
  logic              in_acc;
  tpl_act_t          act;
  point_t            in_pt;
  logic [CNTW-1:0]   cap_eff;
  logic [CNTW-1:0]   count_inc;
  logic              is_query;
  logic              tail_hit;
  tpl_tok_t          inject;
  tpl_tok_t          cell_tok [DEPTH];
  point_t            cell_pt  [DEPTH];

  assign act      = tpl_act_t'(in_tuser);
  assign in_tready = (state_r == S_IDLE) && (!out_tvalid_r || out_tready);
  assign in_acc   = in_tvalid && in_tready;
  assign is_query = (act == ACT_NEAR) || (act == ACT_EXACT);

  always_comb begin
    for (int k = 0; k < DIMS; k++) begin
      in_pt[k] = in_tdata[k*CW +: CW];
    end
  end

  always_comb begin
    inject          = '0;
    inject.valid    = in_acc && is_query;
    inject.near     = (act == ACT_NEAR);
    inject.pt       = in_pt;
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    if (i == 0) begin : g_head
      tpl_cell u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .cell_idx (IDXW'(i)),
        .count    (count_r),
        .radius   (radius_r),
        .shift_en (in_acc && (act == ACT_INSERT)),
        .point_in (in_pt),
        .point_out(cell_pt[i]),
        .tok_in   (inject),
        .tok_out  (cell_tok[i])
      );
    end else begin : g_body
      tpl_cell u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .cell_idx (IDXW'(i)),
        .count    (count_r),
        .radius   (radius_r),
        .shift_en (in_acc && (act == ACT_INSERT)),
        .point_in (cell_pt[i-1]),
        .point_out(cell_pt[i]),
        .tok_in   (cell_tok[i-1]),
        .tok_out  (cell_tok[i])
      );
    end
  end

  assign tail_hit = tpl_match(cell_tok[DEPTH-1], radius_r);

  always_comb begin
    priority if (capacity_r == '0) begin
      cap_eff = CNTW'(1);
    end else if (CNTW'(capacity_r) > CNTW'(DEPTH)) begin
      cap_eff = CNTW'(DEPTH);
    end else begin
      cap_eff = CNTW'(capacity_r);
    end
  end

  assign count_inc = count_r + CNTW'(1);

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    out_load       = 1'b0;
    out_data_nxt   = out_data_r;
    if (in_acc) begin
      unique case (act)
        ACT_INSERT: begin
          count_nxt    = (count_inc > cap_eff) ? cap_eff : count_inc;
          out_load     = 1'b1;
          out_data_nxt = {count_nxt, IDXW'(0), 1'b0};
        end
        ACT_CLEAR: begin
          count_nxt    = '0;
          out_load     = 1'b1;
          out_data_nxt = {CNTW'(0), IDXW'(0), 1'b0};
        end
        ACT_NEAR, ACT_EXACT: begin
          state_nxt = S_SCAN;
        end
        default: begin
          state_nxt = state_r;
        end
      endcase
    end
    if (cell_tok[DEPTH-1].valid) begin
      state_nxt = S_IDLE;
      out_load  = 1'b1;
      priority if (cell_tok[DEPTH-1].found) begin
        out_data_nxt = {count_r, cell_tok[DEPTH-1].idx, 1'b1};
      end else if (tail_hit) begin
        out_data_nxt = {count_r, cell_tok[DEPTH-1].pend_idx, 1'b1};
      end else begin
        out_data_nxt = {count_r, IDXW'(0), 1'b0};
      end
    end
    out_tvalid_nxt = out_load ? 1'b1 : (out_tready ? 1'b0 : out_tvalid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      count_r      <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      count_r      <= count_nxt;
      out_tvalid_r <= out_tvalid_nxt;
      if (out_load) begin
        out_data_r <= out_data_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r   <= '0;
      capacity_r <= CAPW'(16);
    end else if (cfg_wr_en) begin
      unique case (cfg_addr)
        CFG_RADIUS:   radius_r   <= cfg_wr_data;
        CFG_CAPACITY: capacity_r <= cfg_wr_data[CAPW-1:0];
        default:      radius_r   <= radius_r;
      endcase
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {(16 - OUTW)'(0), out_data_r};

  a_no_accept_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> !in_tready)
    else $error("request accepted during query walk");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNTW'(DEPTH))
    else $error("entry count above depth");

  a_tail_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    cell_tok[DEPTH-1].valid |-> (state_r == S_SCAN))
    else $error("query result outside walk");

  a_query_no_early_out: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && is_query) |=> !out_tvalid_r)
    else $error("result shown before query walk finished");

endmodule
